[design/assert_macros.svh]
// Assertion macros used by the RTL.
// AST_NOW checks that the consequent holds in the same cycle as the antecedent.
// AST_NEXT checks that the consequent holds in the cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AST_NOW(label, clk, rst, ante, cons)
`define AST_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/u2b_pkg.sv]
`default_nettype none

package u2b_pkg;

   localparam logic [15:0] REPLACEMENT_UNIT = 16'h001A;
   localparam logic [31:0] HIGH_SURR_FIRST  = 32'h0000_D800;
   localparam logic [31:0] HIGH_SURR_LAST   = 32'h0000_DBFF;
   localparam logic [31:0] BMP_MAX          = 32'h0000_FFFF;

   // One result of the decoder
   typedef struct packed {
      logic [15:0] code_unit;
      logic        has_char;
      logic        substituted;
      logic        last;
   } u2b_result_type;

   // Trailing byte count of a lead byte
   function automatic logic [2:0] lead_extra(input logic [7:0] b);
      logic [2:0] n;
      case (b) inside
         [8'h00:8'hBF]: n = 3'd0;
         [8'hC0:8'hDF]: n = 3'd1;
         [8'hE0:8'hEF]: n = 3'd2;
         [8'hF0:8'hF7]: n = 3'd3;
         [8'hF8:8'hFB]: n = 3'd4;
         default:       n = 3'd5;
      endcase
      return n;
   endfunction

   // Offset removed from the accumulator once a sequence completes
   function automatic logic [31:0] seq_offset(input logic [2:0] extra);
      logic [31:0] off;
      case (extra)
         3'd1:    off = 32'h0000_3080;
         3'd2:    off = 32'h000E_2080;
         3'd3:    off = 32'h03C8_2080;
         3'd4:    off = 32'hFA08_2080;
         3'd5:    off = 32'h8208_2080;
         default: off = 32'h0000_0000;
      endcase
      return off;
   endfunction

endpackage

`default_nettype wire

[design/utf8_to_bmp_decoder.sv]
// Channel   Dir  Handshake            Fields
// request   in   req_valid/req_ready  req_in_byte, req_end_of_string
// response  out  rsp_valid/rsp_ready  rsp_code_unit, rsp_has_char, rsp_substituted, rsp_last
//
// One byte per cycle unless the buffer is full: a request is registered, then
// decoded, and any response goes through the two-entry buffer before it is visible.
// The limit is the shift-add and offset subtract on the 32-bit accumulator.
// Reset clears the sequence state and empties the two-entry response buffer.
// A stalled response side fills the buffer; requests stop only when it is full.
`default_nettype none
`include "assert_macros.svh"

module utf8_to_bmp_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_string,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [15:0] rsp_code_unit,
   output      logic        rsp_has_char,
   output      logic        rsp_substituted,
   output      logic        rsp_last
);
   import u2b_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_eos_ff;
   logic           room;
   logic [1:0]     buf_count;
   logic           advance;
   logic           emit;
   logic           req_take;
   u2b_result_type dec_result;
   u2b_result_type rsp_data;

   // Input register: move on whenever the buffer has space
   assign advance     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || room;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_string;
      end
   end

   u2b_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .in_byte       (in_byte_ff),
      .end_of_string (in_eos_ff),
      .emit          (emit),
      .result        (dec_result)
   );

   u2b_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && emit),
      .push_data (dec_result),
      .room      (room),
      .count     (buf_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_code_unit   = rsp_data.code_unit;
   assign rsp_has_char    = rsp_data.has_char;
   assign rsp_substituted = rsp_data.substituted;
   assign rsp_last        = rsp_data.last;

   `AST_NOW(a_buf_bound, clock, reset, 1'b1, buf_count != 2'd3)
   `AST_NOW(a_empty_marks_end, clock, reset, rsp_valid && !rsp_has_char,
            rsp_last && (rsp_code_unit == 16'd0))
   `AST_NOW(a_sub_unit, clock, reset, rsp_valid && rsp_substituted,
            rsp_has_char && (rsp_code_unit == REPLACEMENT_UNIT))
   `AST_NEXT(a_full_stalls, clock, reset, in_valid_ff && !room,
             in_valid_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire

[design/u2b_decode.sv]
`default_nettype none

module u2b_decode (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    end_of_string,
   output      logic                    emit,
   output      u2b_pkg::u2b_result_type result
);
   import u2b_pkg::*;

   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]  seq_extra_ff, seq_extra_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  left_next;
   logic [2:0]  extra_next;
   logic [31:0] acc_next;
   logic [31:0] ch;
   logic        done;
   logic        sub;

   // Fold the byte into the sequence state
   always_comb begin
      if (bytes_left_ff == 3'd0) begin
         extra_next = lead_extra(in_byte);
         left_next  = extra_next;
         acc_next   = {24'd0, in_byte};
      end else begin
         extra_next = seq_extra_ff;
         left_next  = bytes_left_ff - 3'd1;
         acc_next   = {acc_ff[25:0], 6'd0} + {24'd0, in_byte};
      end
   end

   // Finish the code point and substitute code points above the BMP and high surrogates
   assign done = (left_next == 3'd0);
   assign ch   = acc_next - seq_offset(extra_next);
   assign sub  = (ch > BMP_MAX) || ((ch >= HIGH_SURR_FIRST) && (ch <= HIGH_SURR_LAST));
   assign emit = done || end_of_string;

   always_comb begin
      result.last = end_of_string;
      if (done) begin
         result.code_unit   = sub ? REPLACEMENT_UNIT : ch[15:0];
         result.has_char    = 1'b1;
         result.substituted = sub;
      end else begin
         result.code_unit   = 16'd0;
         result.has_char    = 1'b0;
         result.substituted = 1'b0;
      end
   end

   // Drop all sequence state at the end of a string
   always_comb begin
      bytes_left_in = bytes_left_ff;
      seq_extra_in  = seq_extra_ff;
      acc_in        = acc_ff;
      if (step) begin
         if (end_of_string) begin
            bytes_left_in = 3'd0;
            seq_extra_in  = 3'd0;
            acc_in        = 32'd0;
         end else begin
            bytes_left_in = left_next;
            seq_extra_in  = extra_next;
            acc_in        = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 3'd0;
         seq_extra_ff  <= 3'd0;
         acc_ff        <= 32'd0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         seq_extra_ff  <= seq_extra_in;
         acc_ff        <= acc_in;
      end
   end

endmodule

`default_nettype wire

[design/u2b_out_buf.sv]
`default_nettype none

module u2b_out_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire u2b_pkg::u2b_result_type push_data,
   output      logic                    room,
   output      logic [1:0]              count,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      u2b_pkg::u2b_result_type rsp_data
);
   import u2b_pkg::*;

   u2b_result_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           pop;

   assign room      = (count_ff != 2'd2);
   assign count     = count_ff;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold results until taken
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire
